// ===== hw/rtl/gcr_pkg.sv =====
// Shared types and constants of the glyph column rasterizer.
`timescale 1ns / 1ps
`default_nettype none

package gcr_pkg;

  localparam int FRAME_WIDTH_DEF  = 1024;
  localparam int FRAME_HEIGHT_DEF = 600;

  localparam int COORD_W  = 10;
  localparam int GH_W     = 6;
  localparam int COLOR_W  = 32;
  localparam int INDEX_W  = 20;
  localparam int BYTE_W   = 8;
  localparam int ROW_W    = COORD_W + 1;
  localparam int CMP_W    = 13;
  localparam int CFG_IDX_W = 2;

  localparam int QUEUE_DEPTH = 2;

  // Register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_GLYPH_HEIGHT   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LANDSCAPE_MODE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_INK_COLOUR     = 2'd2;

  localparam logic [GH_W-1:0]    GLYPH_HEIGHT_RST = 6'd12;
  localparam logic               LANDSCAPE_RST    = 1'b1;
  localparam logic [COLOR_W-1:0] INK_COLOUR_RST   = '0;

  typedef struct packed {
    logic [GH_W-1:0]    glyph_height;
    logic               landscape_mode;
    logic [COLOR_W-1:0] ink_colour;
  } gcr_cfg_t;

  // One classified byte: column base, first row and the steps that write
  typedef struct packed {
    logic [INDEX_W-1:0] base_mul;
    logic [ROW_W-1:0]   row0;
    logic [BYTE_W-1:0]  mask;
  } gcr_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/gcr_ifs.sv =====
// Handshake channel interfaces: glyph bytes in, pixel writes out, register writes.
`timescale 1ns / 1ps
`default_nettype none

interface gcr_in_if;
  logic                        valid;
  logic                        ready;
  logic                        start_glyph;
  logic [gcr_pkg::COORD_W-1:0] origin_x;
  logic [gcr_pkg::COORD_W-1:0] origin_y;
  logic [gcr_pkg::BYTE_W-1:0]  glyph_byte;

  modport source (output valid, start_glyph, origin_x, origin_y, glyph_byte, input ready);
  modport sink   (input valid, start_glyph, origin_x, origin_y, glyph_byte, output ready);
endinterface

interface gcr_out_if;
  logic                        valid;
  logic                        ready;
  logic [gcr_pkg::INDEX_W-1:0] pixel_index;
  logic [gcr_pkg::COLOR_W-1:0] pixel_color;
  logic                        last_write;

  modport source (output valid, pixel_index, pixel_color, last_write, input ready);
  modport sink   (input valid, pixel_index, pixel_color, last_write, output ready);
endinterface

interface gcr_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [gcr_pkg::CFG_IDX_W-1:0] index;
  logic [gcr_pkg::COLOR_W-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/glyph_column_rasterizer_core.sv =====
// Glyph column rasterizer: bitmap font bytes in, framebuffer pixel writes out.
//
// Channels: in_if takes one font byte per word with its start flag and glyph
// origin; out_if gives one pixel write per word (index, colour, last-of-byte
// flag); cfg_if writes glyph height, display direction and pen colour and is
// always ready. Write configuration only while no byte is in flight.
// Flow: a taken byte goes through the queue, the back end's mask register and
// the output register. Throughput: one pixel word per cycle while out_if.ready
// is high, set by the back end issuing one mask bit per cycle. A byte writes 0
// to 8 pixels; one that writes nothing is never queued. The front end keeps
// taking bytes into a two-entry queue while the back end works.
// Reset: cursor and column top go to (0,0), registers to height 12,
// landscape, colour 0; queue and output are emptied.
// Stall: when the receiver holds ready low the output word is held, the back
// end stops and the queue fills, after which in_if.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module glyph_column_rasterizer_core #(
  parameter int FRAME_WIDTH  = gcr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = gcr_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  gcr_in_if.sink    in_if,
  gcr_out_if.source out_if,
  gcr_cfg_if.sink   cfg_if
);

  gcr_pkg::gcr_cfg_t   cfg_q, cfg_d;
  gcr_pkg::gcr_entry_t push_entry, pop_entry;
  logic                push_valid, push_ready, pop_valid, pop_ready;

  assign cfg_if.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_if.valid) begin
      case (cfg_if.index)
        gcr_pkg::REG_GLYPH_HEIGHT:   cfg_d.glyph_height   = cfg_if.data[gcr_pkg::GH_W-1:0];
        gcr_pkg::REG_LANDSCAPE_MODE: cfg_d.landscape_mode = cfg_if.data[0];
        gcr_pkg::REG_INK_COLOUR:     cfg_d.ink_colour     = cfg_if.data;
        default:                     cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.glyph_height   <= gcr_pkg::GLYPH_HEIGHT_RST;
      cfg_q.landscape_mode <= gcr_pkg::LANDSCAPE_RST;
      cfg_q.ink_colour     <= gcr_pkg::INK_COLOUR_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  gcr_front #(
    .FRAME_WIDTH  (FRAME_WIDTH),
    .FRAME_HEIGHT (FRAME_HEIGHT)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_if        (in_if),
    .cfg_i        (cfg_q),
    .push_entry_o (push_entry),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready)
  );

  gcr_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_entry_i (push_entry),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .pop_entry_o  (pop_entry),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready)
  );

  gcr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .pop_entry_i (pop_entry),
    .pop_valid_i (pop_valid),
    .pop_ready_o (pop_ready),
    .out_if      (out_if)
  );

  // The front end never queues a byte that writes nothing
  a_entry_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_valid |-> (pop_entry.mask != '0))
    else $error("empty entry in queue");

  // A full queue must have something to hand on
  a_full_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_if.ready |-> pop_valid)
    else $error("input stalled with empty queue");

  // Pixels of one byte follow without gaps
  a_no_gap_in_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && out_if.ready && !out_if.last_write) |=> out_if.valid)
    else $error("gap inside a byte's pixel run");

endmodule

`default_nettype wire

// ===== hw/rtl/gcr_front.sv =====
// Front end: tracks the glyph cursor and classifies each byte into a queue entry.
`timescale 1ns / 1ps
`default_nettype none

module gcr_front #(
  parameter int FRAME_WIDTH  = gcr_pkg::FRAME_WIDTH_DEF,
  parameter int FRAME_HEIGHT = gcr_pkg::FRAME_HEIGHT_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  gcr_in_if.sink                   in_if,
  input  wire gcr_pkg::gcr_cfg_t   cfg_i,
  output gcr_pkg::gcr_entry_t      push_entry_o,
  output logic                     push_valid_o,
  input  wire logic                push_ready_i
);

  localparam logic [gcr_pkg::CMP_W-1:0] FW_C  = gcr_pkg::CMP_W'(FRAME_WIDTH);
  localparam logic [gcr_pkg::CMP_W-1:0] FH_C  = gcr_pkg::CMP_W'(FRAME_HEIGHT);
  localparam logic [gcr_pkg::CMP_W-1:0] FH_M1 = gcr_pkg::CMP_W'(FRAME_HEIGHT - 1);

  logic [gcr_pkg::COORD_W-1:0] cur_x_q, cur_x_d;
  logic [gcr_pkg::COORD_W-1:0] cur_y_q, cur_y_d;
  logic [gcr_pkg::COORD_W-1:0] top_q, top_d;

  logic [gcr_pkg::COORD_W-1:0] cx, cy, top, offset, remain;
  logic [gcr_pkg::ROW_W-1:0]   row0;
  logic [gcr_pkg::CMP_W-1:0]   xp;
  logic [3:0]                  n_steps;
  logic                        col_end, x_in, accept;
  logic [gcr_pkg::BYTE_W-1:0]  mask;

  assign accept = in_if.valid && in_if.ready;
  assign in_if.ready = push_ready_i;

  always_comb begin
    cx     = in_if.start_glyph ? in_if.origin_x : cur_x_q;
    cy     = in_if.start_glyph ? in_if.origin_y : cur_y_q;
    top    = in_if.start_glyph ? in_if.origin_y : top_q;
    offset = cy - top;
    remain = gcr_pkg::COORD_W'(cfg_i.glyph_height) - offset;
    // A remainder of zero means a full wrap of the row counter
    col_end = (remain != '0) && (remain <= gcr_pkg::COORD_W'(8));
    n_steps = col_end ? remain[3:0] : 4'd8;
    row0    = gcr_pkg::ROW_W'(top) + gcr_pkg::ROW_W'(offset);
    x_in    = gcr_pkg::CMP_W'(cx) < FH_C;
    for (int j = 0; j < gcr_pkg::BYTE_W; j++) begin
      mask[j] = (4'(j) < n_steps) && in_if.glyph_byte[gcr_pkg::BYTE_W-1-j] && x_in &&
                ((gcr_pkg::CMP_W'(row0) + gcr_pkg::CMP_W'(j)) < FW_C);
    end
    xp = cfg_i.landscape_mode ? gcr_pkg::CMP_W'(cx) : (FH_M1 - gcr_pkg::CMP_W'(cx));

    push_entry_o.base_mul = gcr_pkg::INDEX_W'(FW_C) * gcr_pkg::INDEX_W'(xp);
    push_entry_o.row0     = row0;
    push_entry_o.mask     = mask;
    // Drop bytes that write nothing
    push_valid_o = in_if.valid && (mask != '0);

    if (col_end) begin
      cur_x_d = cx + gcr_pkg::COORD_W'(1);
      cur_y_d = top;
    end else begin
      cur_x_d = cx;
      cur_y_d = cy + gcr_pkg::COORD_W'(8);
    end
    top_d = top;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q <= '0;
      cur_y_q <= '0;
      top_q   <= '0;
    end else if (accept) begin
      cur_x_q <= cur_x_d;
      cur_y_q <= cur_y_d;
      top_q   <= top_d;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcr_queue.sv =====
// Short queue of classified bytes between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none

module gcr_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gcr_pkg::gcr_entry_t push_entry_i,
  input  wire logic                push_valid_i,
  output logic                     push_ready_o,
  output gcr_pkg::gcr_entry_t      pop_entry_o,
  output logic                     pop_valid_o,
  input  wire logic                pop_ready_i
);

  localparam int DEPTH = gcr_pkg::QUEUE_DEPTH;
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  gcr_pkg::gcr_entry_t entries_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign push_ready_o = count_q != CNT_W'(DEPTH);
  assign pop_valid_o  = count_q != '0;
  assign pop_entry_o  = entries_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_valid_o && pop_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gcr_back.sv =====
// Back end: walks each entry's write mask, one pixel word a cycle unless stalled.
`timescale 1ns / 1ps
`default_nettype none

module gcr_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire gcr_pkg::gcr_cfg_t   cfg_i,
  input  wire gcr_pkg::gcr_entry_t pop_entry_i,
  input  wire logic                pop_valid_i,
  output logic                     pop_ready_o,
  gcr_out_if.source                out_if
);

  logic [gcr_pkg::INDEX_W-1:0] base_q, base_d;
  logic [gcr_pkg::BYTE_W-1:0]  mask_q, mask_d, rem;
  logic [2:0]                  cur_j;
  logic                        advance, need_load;

  logic                        out_valid_q, out_valid_d;
  logic [gcr_pkg::INDEX_W-1:0] out_index_q, out_index_d;
  logic [gcr_pkg::COLOR_W-1:0] out_color_q, out_color_d;
  logic                        out_last_q, out_last_d;

  always_comb begin
    cur_j = '0;
    for (int j = gcr_pkg::BYTE_W - 1; j >= 0; j--) begin
      if (mask_q[j]) begin
        cur_j = 3'(j);
      end
    end
    rem = mask_q & ~(gcr_pkg::BYTE_W'(1) << cur_j);

    advance   = !out_valid_q || out_if.ready;
    // Fetch the next entry once the current one has issued its final word
    need_load = (mask_q == '0) || (advance && (rem == '0));
    pop_ready_o = need_load;

    out_valid_d = out_valid_q;
    out_index_d = out_index_q;
    out_color_d = out_color_q;
    out_last_d  = out_last_q;
    if (advance) begin
      out_valid_d = mask_q != '0;
      out_index_d = base_q + gcr_pkg::INDEX_W'(cur_j);
      out_color_d = cfg_i.ink_colour;
      out_last_d  = rem == '0;
    end

    base_d = base_q;
    mask_d = mask_q;
    if (need_load) begin
      mask_d = pop_valid_i ? pop_entry_i.mask : '0;
      base_d = pop_entry_i.base_mul + gcr_pkg::INDEX_W'(pop_entry_i.row0);
    end else if (advance) begin
      mask_d = rem;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      mask_q      <= mask_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q      <= base_d;
    out_index_q <= out_index_d;
    out_color_q <= out_color_d;
    out_last_q  <= out_last_d;
  end

  assign out_if.valid       = out_valid_q;
  assign out_if.pixel_index = out_index_q;
  assign out_if.pixel_color = out_color_q;
  assign out_if.last_write  = out_last_q;

endmodule

`default_nettype wire

// ===== dv/testbench.sv =====
// Self-checking testbench of the glyph column rasterizer core.
`timescale 1ns / 1ps

module testbench;
  import gcr_pkg::*;

  localparam int FRAME_W     = FRAME_WIDTH_DEF;
  localparam int FRAME_H     = FRAME_HEIGHT_DEF;
  localparam int ITEMS       = 460;
  localparam int DRAIN       = 16;
  localparam int LONG_HOLD   = 400;
  localparam int CYCLE_LIMIT = 300000;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e           kind;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [COLOR_W-1:0]  reg_data;
    logic                start;
    logic [COORD_W-1:0]  ox;
    logic [COORD_W-1:0]  oy;
    logic [BYTE_W-1:0]   gbyte;
    bit                  known;
    int                  known_n;
    logic [INDEX_W-1:0]  known_idx;
    logic [COLOR_W-1:0]  known_col;
  } row_t;

  typedef struct packed {
    logic [INDEX_W-1:0] index;
    logic [COLOR_W-1:0] color;
    logic               last;
  } pixel_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  gcr_in_if  in_if ();
  gcr_out_if out_if ();
  gcr_cfg_if cfg_if ();

  glyph_column_rasterizer_core #(
    .FRAME_WIDTH  (FRAME_W),
    .FRAME_HEIGHT (FRAME_H)
  ) DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow registers and cursor of the rasterizer
  logic [GH_W-1:0]    cfg_height;
  logic               cfg_land;
  logic [COLOR_W-1:0] cfg_pen;
  logic [COORD_W-1:0] cur_x;
  logic [COORD_W-1:0] cur_y;
  logic [COORD_W-1:0] col_top;

  pixel_t pending_pixels[$];
  pixel_t byte_pixels[$];
  row_t   stim_rows[$];

  int err_cnt        = 0;
  int pixels_checked = 0;
  int bytes_sent     = 0;
  int phases         = 0;
  int cycle_cnt      = 0;

  // Sender and receiver pacing
  bit tx_gappy  = 1'b1;
  int burst_left = 4;
  int rx_mode   = 0;
  int hold_ticket = 0;

  function automatic row_t cfg_row(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
    row_t r;
    r = '{ROW_CFG, idx, data, 1'b0, '0, '0, '0, 1'b0, 0, '0, '0};
    return r;
  endfunction

  function automatic row_t byte_row(logic st, logic [COORD_W-1:0] ox,
                                    logic [COORD_W-1:0] oy, logic [BYTE_W-1:0] b);
    row_t r;
    r = '{ROW_BYTE, '0, '0, st, ox, oy, b, 1'b0, 0, '0, '0};
    return r;
  endfunction

  function automatic row_t known_row(logic st, logic [COORD_W-1:0] ox,
                                     logic [COORD_W-1:0] oy, logic [BYTE_W-1:0] b, int n,
                                     logic [INDEX_W-1:0] idx, logic [COLOR_W-1:0] col);
    row_t r;
    r = '{ROW_BYTE, '0, '0, st, ox, oy, b, 1'b1, n, idx, col};
    return r;
  endfunction

  function automatic logic [BYTE_W-1:0] rand_glyph_byte();
    int pick;
    pick = $urandom_range(0, 19);
    if (pick < 5) return 8'h00;
    if (pick < 8) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // Scan one font byte from the current cursor, filling byte_pixels
  function automatic void rasterise_byte(logic st, logic [COORD_W-1:0] ox,
                                         logic [COORD_W-1:0] oy, logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0]  bits;
    logic [COORD_W-1:0] off;
    int                 row;
    int                 line;
    int                 ix;
    bit                 col_end;
    bits = b;
    col_end = 1'b0;
    byte_pixels.delete();
    if (st) begin
      cur_x   = ox;
      cur_y   = oy;
      col_top = oy;
    end
    for (int j = 0; j < 8 && !col_end; j++) begin
      off = cur_y - col_top;
      row = int'(col_top) + int'(off);
      if (bits[7] && int'(cur_x) < FRAME_H && row < FRAME_W) begin
        line = cfg_land ? int'(cur_x) : FRAME_H - 1 - int'(cur_x);
        ix   = line * FRAME_W + row;
        byte_pixels.push_back(pixel_t'{ix[INDEX_W-1:0], cfg_pen, 1'b0});
      end
      bits  = bits << 1;
      cur_y = cur_y + 1'b1;
      off   = cur_y - col_top;
      if (off == COORD_W'(cfg_height)) begin
        cur_y   = col_top;
        cur_x   = cur_x + 1'b1;
        col_end = 1'b1;
      end
    end
    if (byte_pixels.size() > 0) byte_pixels[byte_pixels.size()-1].last = 1'b1;
  endfunction

  task automatic flag_error(string msg);
    err_cnt++;
    if (err_cnt <= 10) $display("%s", msg);
  endtask

  task automatic put_byte(row_t r);
    in_if.valid       <= 1'b1;
    in_if.start_glyph <= r.start;
    in_if.origin_x    <= r.ox;
    in_if.origin_y    <= r.oy;
    in_if.glyph_byte  <= r.gbyte;
    do @(posedge clk_i); while (!in_if.ready);
    rasterise_byte(r.start, r.ox, r.oy, r.gbyte);
    if (r.known) begin
      if (r.known_n > 0) pending_pixels.push_back(pixel_t'{r.known_idx, r.known_col, 1'b1});
    end else begin
      foreach (byte_pixels[k]) pending_pixels.push_back(byte_pixels[k]);
    end
    bytes_sent++;
    if (tx_gappy) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        in_if.valid <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  task automatic hold_input();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic wait_idle();
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
    repeat (DRAIN) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [COLOR_W-1:0] data);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= data;
    do @(posedge clk_i); while (!cfg_if.ready);
    case (idx)
      REG_GLYPH_HEIGHT:   cfg_height = data[GH_W-1:0];
      REG_LANDSCAPE_MODE: cfg_land   = data[0];
      REG_INK_COLOUR:     cfg_pen    = data;
      default: ;
    endcase
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // Pixel write checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (out_if.valid && out_if.ready) begin
      if (pending_pixels.size() == 0) begin
        flag_error($sformatf("unexpected pixel write: idx %0d col %h last %0b",
                             out_if.pixel_index, out_if.pixel_color, out_if.last_write));
      end else begin
        want = pending_pixels.pop_front();
        if (out_if.pixel_index !== want.index || out_if.pixel_color !== want.color ||
            out_if.last_write !== want.last) begin
          flag_error($sformatf({"pixel %0d mismatch: expected idx %0d col %h last %0b, ",
                                "got idx %0d col %h last %0b"},
                               pixels_checked, want.index, want.color, want.last,
                               out_if.pixel_index, out_if.pixel_color, out_if.last_write));
        end
      end
      pixels_checked++;
    end
  end

  // Receiver: own stall pattern, plus a long hold-off on request
  initial begin
    int             hold_seen;
    int             hold_left;
    logic [7:0]     rx_pat;
    hold_seen = 0;
    hold_left = 0;
    rx_pat    = 8'b1011_0110;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_ticket != hold_seen) begin
        hold_seen = hold_ticket;
        hold_left = LONG_HOLD;
      end
      rx_pat = {rx_pat[0], rx_pat[7:1]};
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        case (rx_mode)
          0: out_if.ready <= 1'b1;
          1: out_if.ready <= ($urandom_range(0, 3) != 0);
          2: out_if.ready <= ($urandom_range(0, 9) < 3);
          default: out_if.ready <= rx_pat[0];
        endcase
      end
    end
  end

  // Run limit
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    row_t r;
    int   h;
    int   nom_cols;
    int   n_cols;
    int   bpc;
    int   n_glyphs;
    int   y_top;
    logic [COORD_W-1:0] gx;
    logic [COORD_W-1:0] gy;

    rst_ni            <= 1'b0;
    in_if.valid       <= 1'b0;
    in_if.start_glyph <= 1'b0;
    in_if.origin_x    <= '0;
    in_if.origin_y    <= '0;
    in_if.glyph_byte  <= '0;
    cfg_if.valid      <= 1'b0;
    cfg_if.index      <= '0;
    cfg_if.data       <= '0;
    cfg_height = GLYPH_HEIGHT_RST;
    cfg_land   = LANDSCAPE_RST;
    cfg_pen    = INK_COLOUR_RST;
    cur_x      = '0;
    cur_y      = '0;
    col_top    = '0;

    // Directed part
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'h80, 1, 20'd0, 32'h0));
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'h00, 0, '0, '0));
    stim_rows.push_back(cfg_row(REG_INK_COLOUR, 32'hFFFF_FFFF));
    stim_rows.push_back(known_row(1'b1, 10'd599, 10'd1023, 8'h80, 1, 20'd614399, 32'hFFFF_FFFF));
    stim_rows.push_back(byte_row(1'b1, 10'd0, 10'd0, 8'hFF));
    stim_rows.push_back(byte_row(1'b0, 10'd1023, 10'd1023, 8'hFF));
    stim_rows.push_back(known_row(1'b1, 10'd600, 10'd5, 8'hFF, 0, '0, '0));
    stim_rows.push_back(known_row(1'b1, 10'd1023, 10'd1020, 8'hFF, 0, '0, '0));
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'hF0, 0, '0, '0));
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'h80, 1, 20'd1020, 32'hFFFF_FFFF));
    stim_rows.push_back(byte_row(1'b1, 10'd10, 10'd1020, 8'hFF));
    stim_rows.push_back(cfg_row(REG_GLYPH_HEIGHT, 32'd1));
    stim_rows.push_back(known_row(1'b1, 10'd5, 10'd7, 8'hFF, 1, 20'd5127, 32'hFFFF_FFFF));
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'hAA, 1, 20'd6151, 32'hFFFF_FFFF));
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'h7F, 0, '0, '0));
    stim_rows.push_back(cfg_row(REG_LANDSCAPE_MODE, 32'd0));
    stim_rows.push_back(cfg_row(REG_INK_COLOUR, 32'h5A5A_A5A5));
    stim_rows.push_back(known_row(1'b1, 10'd0, 10'd0, 8'h80, 1, 20'd613376, 32'h5A5A_A5A5));
    stim_rows.push_back(cfg_row(REG_GLYPH_HEIGHT, 32'd63));
    stim_rows.push_back(byte_row(1'b1, 10'd599, 10'd0, 8'hFF));
    stim_rows.push_back(byte_row(1'b0, 10'd0, 10'd0, 8'h55));
    stim_rows.push_back(cfg_row(REG_GLYPH_HEIGHT, 32'd0));
    stim_rows.push_back(byte_row(1'b1, 10'd300, 10'd1000, 8'hFF));
    stim_rows.push_back(byte_row(1'b0, 10'd0, 10'd0, 8'hFF));
    stim_rows.push_back(byte_row(1'b0, 10'd0, 10'd0, 8'hFF));
    stim_rows.push_back(known_row(1'b0, 10'd0, 10'd0, 8'hFF, 0, '0, '0));
    stim_rows.push_back(cfg_row(REG_GLYPH_HEIGHT, 32'd32));
    stim_rows.push_back(cfg_row(REG_LANDSCAPE_MODE, 32'd1));
    stim_rows.push_back(cfg_row(REG_INK_COLOUR, 32'h0));
    stim_rows.push_back(byte_row(1'b1, 10'd1, 10'd2, 8'h01));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    rx_mode <= 1;
    foreach (stim_rows[i]) begin
      if (stim_rows[i].kind == ROW_CFG) begin
        hold_input();
        wait_idle();
        write_reg(stim_rows[i].reg_idx, stim_rows[i].reg_data);
      end else begin
        put_byte(stim_rows[i]);
      end
    end
    hold_input();
    wait_idle();

    // Random part: whole glyphs of random content, with some broken runs
    while (bytes_sent < ITEMS) begin
      case ($urandom_range(0, 9))
        0, 1:    h = $urandom_range(0, 63);
        2, 3:    h = 12;
        4, 5:    h = 16;
        6, 7:    h = 24;
        default: h = 32;
      endcase
      write_reg(REG_GLYPH_HEIGHT, 32'(h));
      write_reg(REG_LANDSCAPE_MODE, 32'($urandom_range(0, 1)));
      case ($urandom_range(0, 5))
        0:       write_reg(REG_INK_COLOUR, 32'h0);
        1:       write_reg(REG_INK_COLOUR, 32'hFFFF_FFFF);
        default: write_reg(REG_INK_COLOUR, $urandom());
      endcase
      rx_mode  <= $urandom_range(0, 3);
      tx_gappy = ($urandom_range(0, 3) != 0);
      if (phases == 1) begin
        // fill the block against a stalled receiver
        hold_ticket <= hold_ticket + 1;
        tx_gappy = 1'b0;
        repeat (24) put_byte(byte_row(1'b1, '0, '0, 8'hFF));
      end

      case (h)
        12:      nom_cols = 6;
        16:      nom_cols = 8;
        24:      nom_cols = 12;
        32:      nom_cols = 32;
        default: nom_cols = 8;
      endcase
      bpc = (h == 0) ? 4 : (h + 7) / 8;
      y_top = (h == 0) ? 1023 : 1024 - h;
      n_glyphs = $urandom_range(1, 3);

      repeat (n_glyphs) begin
        if ($urandom_range(0, 7) == 0) begin
          repeat ($urandom_range(1, 10)) begin
            r = byte_row($urandom_range(0, 2) == 0, COORD_W'($urandom_range(0, 1023)),
                         COORD_W'($urandom_range(0, 1023)), rand_glyph_byte());
            put_byte(r);
          end
        end else begin
          gx = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom_range(0, 1023))
                                           : COORD_W'($urandom_range(0, FRAME_H - 1));
          gy = ($urandom_range(0, 9) == 0) ? COORD_W'($urandom_range(0, 1023))
                                           : COORD_W'($urandom_range(0, y_top));
          n_cols = $urandom_range(1, nom_cols);
          for (int c = 0; c < n_cols && bytes_sent < ITEMS; c++) begin
            for (int b = 0; b < bpc; b++) begin
              if (c == 0 && b == 0) r = byte_row(1'b1, gx, gy, rand_glyph_byte());
              else r = byte_row(1'b0, COORD_W'($urandom_range(0, 1023)),
                                COORD_W'($urandom_range(0, 1023)), rand_glyph_byte());
              put_byte(r);
            end
          end
        end
      end
      hold_input();
      wait_idle();
      phases++;
    end

    $display("Sent %0d glyph bytes over %0d random register settings plus a directed set;",
             bytes_sent, phases);
    $display("checked %0d pixel writes under bursty input and stalled output.", pixels_checked);
    if (err_cnt == 0 && pending_pixels.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/gcr_pkg.sv
hw/rtl/gcr_ifs.sv
hw/rtl/gcr_front.sv
hw/rtl/gcr_queue.sv
hw/rtl/gcr_back.sv
hw/rtl/glyph_column_rasterizer_core.sv
dv/testbench.sv
